// ===== hw/rtl/hned_pkg.sv =====
package hned_pkg;

   localparam int IDX_W = 4;
   localparam int PROB_W = 16;
   localparam int CSR_DATA_W = 5;
   localparam int PROD_W = 32;
   localparam int ACC_W = 40;
   localparam logic [PROB_W-1:0] Q_ONE = 16'h8000;

   typedef enum logic [1:0] {
      OP_LOAD_TRANS = 2'd0,
      OP_LOAD_EMIT  = 2'd1,
      OP_LOAD_INIT  = 2'd2,
      OP_START      = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_NUM_STATES  = 1'b0,
      CSR_NUM_SYMBOLS = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEL_ISSUE,
      ST_BEL_DRAIN,
      ST_EMI_ISSUE,
      ST_EMI_DRAIN,
      ST_OUT
   } state_type;

   function automatic logic [PROB_W-1:0] sat_prob(input logic [ACC_W-16:0] v);
      logic [PROB_W-1:0] r;
      if (v > (ACC_W-15)'(Q_ONE)) begin
         r = Q_ONE;
      end else begin
         r = v[PROB_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hned_if.sv =====
interface hned_req_if;
   logic                             valid;
   logic                             ready;
   hned_pkg::op_type                 operation;
   logic [hned_pkg::IDX_W-1:0]       row;
   logic [hned_pkg::IDX_W-1:0]       col;
   logic [hned_pkg::PROB_W-1:0]      value;

   modport source (output valid, operation, row, col, value, input ready);
   modport sink (input valid, operation, row, col, value, output ready);
endinterface

interface hned_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hned_pkg::IDX_W-1:0]       symbol_index;
   logic [hned_pkg::PROB_W-1:0]      probability;
   logic                             last;

   modport source (output valid, symbol_index, probability, last, input ready);
   modport sink (input valid, symbol_index, probability, last, output ready);
endinterface

// ===== hw/rtl/hmm_next_emission_distribution.sv =====
// Channel   Dir  Handshake            Payload
// req_chan  in   valid/ready          operation, row, col, value
// rsp_chan  out  valid/ready          symbol_index, probability, last
// csr       in   csr_we (no ready)    csr_index, csr_wdata
//
// Load requests are written as they are taken; req_chan.ready is high only while idle.
// A start request runs on one shared multiplier and accumulator, walking one
// product per cycle while terms are issuing; any rsp stall lengthens it.
// Each sum waits for the RAM read and multiplier stages to drain before the next.
// Reset is synchronous and clears control state; matrix contents stay undefined.
// A stalled response holds the sequencer in its output state.
module hmm_next_emission_distribution #(
   parameter int MAX_STATES  = 16,
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   hned_req_if.sink                          req_chan,
   hned_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  hned_pkg::csr_idx_type             csr_index,
   input  logic [hned_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SW = $clog2(MAX_STATES);
   localparam int KW = $clog2(MAX_SYMBOLS);
   localparam int CSW = $clog2(MAX_STATES + 1);
   localparam int CKW = $clog2(MAX_SYMBOLS + 1);
   localparam int TR_DEPTH = 1 << (2 * SW);
   localparam int EM_DEPTH = 1 << (SW + KW);

   localparam int PW = hned_pkg::PROB_W;
   localparam int AW = hned_pkg::ACC_W;

   hned_pkg::state_type state_ff, state_in;

   logic [CSW-1:0] ns_ff, ns_in;
   logic [CKW-1:0] nk_ff, nk_in;
   logic [SW-1:0]  i_ff, i_in;
   logic [SW-1:0]  j_ff, j_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [SW-1:0]  ns_last;
   logic [KW-1:0]  nk_last;

   logic issue, issue_emi, issue_first, issue_last;
   logic bel_we, out_load, done_clr;

   logic rd_vld_ff, rd_first_ff, rd_last_ff, rd_emi_ff;
   logic prod_vld_ff, prod_first_ff, prod_last_ff;
   logic [hned_pkg::PROD_W-1:0] product_ff;
   logic [AW-1:0] acc_ff, acc_in;
   logic done_ff, done_in;

   logic [hned_pkg::IDX_W-1:0] sym_ff;
   logic [PW-1:0] prob_ff;
   logic last_ff;

   logic req_fire;
   logic [PW-1:0] load_val;
   logic row_ok, col_s_ok, col_k_ok;
   logic tr_we, em_we, in_we;
   logic [PW-1:0] init_q, trans_q, bel_q, emis_q;
   logic [PW-1:0] mul_a, mul_b;
   logic [PW-1:0] acc_prob;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == hned_pkg::ST_IDLE);

   assign load_val = (req_chan.value > hned_pkg::Q_ONE) ? hned_pkg::Q_ONE : req_chan.value;
   assign row_ok   = int'(req_chan.row) < MAX_STATES;
   assign col_s_ok = int'(req_chan.col) < MAX_STATES;
   assign col_k_ok = int'(req_chan.col) < MAX_SYMBOLS;
   assign tr_we = req_fire && (req_chan.operation == hned_pkg::OP_LOAD_TRANS) && row_ok
                  && col_s_ok;
   assign em_we = req_fire && (req_chan.operation == hned_pkg::OP_LOAD_EMIT) && row_ok
                  && col_k_ok;
   assign in_we = req_fire && (req_chan.operation == hned_pkg::OP_LOAD_INIT) && col_s_ok;

   assign ns_last = SW'(ns_ff - 1'b1);
   assign nk_last = KW'(nk_ff - 1'b1);
   assign acc_prob = hned_pkg::sat_prob(acc_ff[AW-1:15]);

   hned_ram #(.WIDTH(PW), .DEPTH(TR_DEPTH)) u_trans (
      .clock (clock),
      .we    (tr_we),
      .waddr ({SW'(req_chan.row), SW'(req_chan.col)}),
      .wdata (load_val),
      .raddr ({i_ff, j_ff}),
      .rdata (trans_q)
   );

   hned_ram #(.WIDTH(PW), .DEPTH(EM_DEPTH)) u_emis (
      .clock (clock),
      .we    (em_we),
      .waddr ({SW'(req_chan.row), KW'(req_chan.col)}),
      .wdata (load_val),
      .raddr ({i_ff, k_ff}),
      .rdata (emis_q)
   );

   hned_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_init (
      .clock (clock),
      .we    (in_we),
      .waddr (SW'(req_chan.col)),
      .wdata (load_val),
      .raddr (i_ff),
      .rdata (init_q)
   );

   hned_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_belief (
      .clock (clock),
      .we    (bel_we),
      .waddr (j_ff),
      .wdata (acc_prob),
      .raddr (i_ff),
      .rdata (bel_q)
   );

   always_comb begin
      ns_in = ns_ff;
      nk_in = nk_ff;
      if (csr_we) begin
         unique case (csr_index)
            hned_pkg::CSR_NUM_STATES: begin
               if (csr_wdata == '0) begin
                  ns_in = CSW'(1);
               end else if (int'(csr_wdata) > MAX_STATES) begin
                  ns_in = CSW'(MAX_STATES);
               end else begin
                  ns_in = CSW'(csr_wdata);
               end
            end
            hned_pkg::CSR_NUM_SYMBOLS: begin
               if (csr_wdata == '0) begin
                  nk_in = CKW'(1);
               end else if (int'(csr_wdata) > MAX_SYMBOLS) begin
                  nk_in = CKW'(MAX_SYMBOLS);
               end else begin
                  nk_in = CKW'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      issue       = 1'b0;
      issue_emi   = 1'b0;
      issue_first = (i_ff == '0);
      issue_last  = (i_ff == ns_last);
      bel_we      = 1'b0;
      out_load    = 1'b0;
      done_clr    = 1'b0;
      unique case (state_ff)
         hned_pkg::ST_IDLE: begin
            if (req_fire && (req_chan.operation == hned_pkg::OP_START)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = hned_pkg::ST_BEL_ISSUE;
            end
         end
         hned_pkg::ST_BEL_ISSUE: begin
            issue = 1'b1;
            if (issue_last) begin
               i_in     = '0;
               state_in = hned_pkg::ST_BEL_DRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         hned_pkg::ST_BEL_DRAIN: begin
            if (done_ff) begin
               bel_we   = 1'b1;
               done_clr = 1'b1;
               if (j_ff == ns_last) begin
                  k_in     = '0;
                  state_in = hned_pkg::ST_EMI_ISSUE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = hned_pkg::ST_BEL_ISSUE;
               end
            end
         end
         hned_pkg::ST_EMI_ISSUE: begin
            issue     = 1'b1;
            issue_emi = 1'b1;
            if (issue_last) begin
               i_in     = '0;
               state_in = hned_pkg::ST_EMI_DRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         hned_pkg::ST_EMI_DRAIN: begin
            if (done_ff) begin
               out_load = 1'b1;
               done_clr = 1'b1;
               state_in = hned_pkg::ST_OUT;
            end
         end
         hned_pkg::ST_OUT: begin
            if (rsp_chan.ready) begin
               if (k_ff == nk_last) begin
                  state_in = hned_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = hned_pkg::ST_EMI_ISSUE;
               end
            end
         end
         default: begin
            state_in = hned_pkg::ST_IDLE;
         end
      endcase
   end

   assign mul_a = rd_emi_ff ? bel_q : init_q;
   assign mul_b = rd_emi_ff ? emis_q : trans_q;

   always_comb begin
      acc_in = acc_ff;
      if (prod_vld_ff) begin
         acc_in = (prod_first_ff ? '0 : acc_ff) + AW'(product_ff);
      end
      done_in = done_ff;
      if (prod_vld_ff && prod_last_ff) begin
         done_in = 1'b1;
      end else if (done_clr) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hned_pkg::ST_IDLE;
         ns_ff       <= CSW'(1);
         nk_ff       <= CKW'(1);
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ns_ff       <= ns_in;
         nk_ff       <= nk_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         acc_ff      <= acc_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff   <= issue_first;
      rd_last_ff    <= issue_last;
      rd_emi_ff     <= issue_emi;
      prod_first_ff <= rd_first_ff;
      prod_last_ff  <= rd_last_ff;
      product_ff    <= hned_pkg::PROD_W'(mul_a) * hned_pkg::PROD_W'(mul_b);
      if (out_load) begin
         sym_ff  <= hned_pkg::IDX_W'(k_ff);
         prob_ff <= acc_prob;
         last_ff <= (k_ff == nk_last);
      end
   end

   assign rsp_chan.valid        = (state_ff == hned_pkg::ST_OUT);
   assign rsp_chan.symbol_index = sym_ff;
   assign rsp_chan.probability  = prob_ff;
   assign rsp_chan.last         = last_ff;

`ifndef NO_ASSERTIONS
   a_issue_no_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hned_pkg::ST_BEL_ISSUE || state_ff == hned_pkg::ST_EMI_ISSUE) |-> !done_ff)
      else $error("sum finished while terms still issuing");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> state_ff == hned_pkg::ST_IDLE)
      else $error("final response did not return to idle");

   a_prob_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.probability <= hned_pkg::Q_ONE)
      else $error("response probability above one");

   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      (ns_ff != '0) && (int'(ns_ff) <= MAX_STATES) && (nk_ff != '0)
      && (int'(nk_ff) <= MAX_SYMBOLS))
      else $error("state or symbol count out of range");
`endif

endmodule

// ===== hw/rtl/hned_ram.sv =====
module hned_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
